@@ hdl/tfew_pkg.sv @@
`timescale 1ns / 1ps
package tfew_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = 32;
  localparam int SW = 64;
  localparam int NW = 96;
  localparam int DW = 95;
  localparam int QW = NW - 1 + FRAC_BITS;

  localparam logic [1:0] CFG_ILLUM_NORM = 2'd0;
  localparam logic [1:0] CFG_UNITY_CLAMP = 2'd1;

  typedef struct packed {
    logic vld;
    logic last;
    logic zero;
    logic rneg;
    logic ineg;
  } ctl_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic zero;
    logic clamped;
    logic sat;
    logic [W-1:0] tr;
    logic [W-1:0] ti;
  } res_t;

endpackage

@@ hdl/tfew_front.sv @@
`timescale 1ns / 1ps
module tfew_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  logic signed [tfew_pkg::W-1:0] wr,
  input  logic signed [tfew_pkg::W-1:0] wi,
  input  logic signed [tfew_pkg::W-1:0] lr,
  input  logic signed [tfew_pkg::W-1:0] li,
  input  logic last_in,
  input  logic signed [tfew_pkg::W-1:0] norm,
  output tfew_pkg::ctl_t ctl,
  output logic [tfew_pkg::QW-1:0] num_r,
  output logic [tfew_pkg::QW-1:0] num_i,
  output logic [tfew_pkg::DW-1:0] den
);

  localparam int W = tfew_pkg::W;
  localparam int SW = tfew_pkg::SW;
  localparam int NW = tfew_pkg::NW;
  localparam int DW = tfew_pkg::DW;
  localparam int F = tfew_pkg::FRAC_BITS;

  tfew_pkg::ctl_t c1, c2, c3;

  // stage 1: S = E*2^F + n*I, |I|^2
  logic [W-1:0] mag_r, mag_i;
  logic [SW-1:0] sq_r, sq_i;
  logic signed [SW-1:0] p_r, p_i;
  logic zero;

  assign mag_r = lr[W-1] ? (~lr + W'(1)) : lr;
  assign mag_i = li[W-1] ? (~li + W'(1)) : li;
  assign sq_r = mag_r * mag_r;
  assign sq_i = mag_i * mag_i;
  assign p_r = norm * lr;
  assign p_i = norm * li;
  assign zero = (norm == '0) || ((lr == '0) && (li == '0));

  logic signed [SW-1:0] sr1, si1;
  logic [SW-1:0] isq1;
  logic signed [W-1:0] ir1, ii1, n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
    end else if (en) begin
      c1.vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1.last <= last_in;
      c1.zero <= zero;
      c1.rneg <= 1'b0;
      c1.ineg <= 1'b0;
      sr1 <= (SW'(wr) <<< F) + p_r;
      si1 <= (SW'(wi) <<< F) + p_i;
      isq1 <= sq_r + sq_i;
      ir1 <= lr;
      ii1 <= li;
      n1 <= norm;
    end
  end

  // stage 2: partial products
  logic signed [SW:0] a_l, b_l, c_l, d_l;
  logic signed [SW-1:0] a_h, b_h, c_h, d_h;
  logic [SW-1:0] dl, dh;
  logic nneg2;
  logic [W-1:0] nmag;

  assign nmag = n1[W-1] ? (~n1 + W'(1)) : n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.vld <= 1'b0;
    end else if (en) begin
      c2.vld <= c1.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2.last <= c1.last;
      c2.zero <= c1.zero;
      c2.rneg <= 1'b0;
      c2.ineg <= 1'b0;
      a_l <= ir1 * $signed({1'b0, sr1[W-1:0]});
      a_h <= ir1 * $signed(sr1[SW-1:W]);
      b_l <= ii1 * $signed({1'b0, si1[W-1:0]});
      b_h <= ii1 * $signed(si1[SW-1:W]);
      c_l <= ir1 * $signed({1'b0, si1[W-1:0]});
      c_h <= ir1 * $signed(si1[SW-1:W]);
      d_l <= ii1 * $signed({1'b0, sr1[W-1:0]});
      d_h <= ii1 * $signed(sr1[SW-1:W]);
      dl <= isq1[W-1:0] * nmag;
      dh <= isq1[SW-1:W] * nmag;
      nneg2 <= n1[W-1];
    end
  end

  // stage 3: N = conj(I)*S, D = |n|*|I|^2
  logic signed [NW-1:0] nr3, ni3;
  logic [DW-1:0] den3;
  logic nneg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3.vld <= 1'b0;
    end else if (en) begin
      c3.vld <= c2.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3.last <= c2.last;
      c3.zero <= c2.zero;
      c3.rneg <= 1'b0;
      c3.ineg <= 1'b0;
      nr3 <= (NW'(a_h) <<< W) + NW'(a_l) + (NW'(b_h) <<< W) + NW'(b_l);
      ni3 <= (NW'(c_h) <<< W) + NW'(c_l) - (NW'(d_h) <<< W) - NW'(d_l);
      den3 <= DW'({dh, {W{1'b0}}}) + DW'(dl);
      nneg3 <= nneg2;
    end
  end

  // stage 4: sign and magnitude of the numerator
  logic [NW-1:0] mr, mi;

  assign mr = nr3[NW-1] ? (~nr3 + NW'(1)) : nr3;
  assign mi = ni3[NW-1] ? (~ni3 + NW'(1)) : ni3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= c3.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.last <= c3.last;
      ctl.zero <= c3.zero;
      ctl.rneg <= nr3[NW-1] ^ nneg3;
      ctl.ineg <= ni3[NW-1] ^ nneg3;
      num_r <= {mr[NW-2:0], {F{1'b0}}};
      num_i <= {mi[NW-2:0], {F{1'b0}}};
      den <= den3;
    end
  end

endmodule

@@ hdl/tfew_div.sv @@
`timescale 1ns / 1ps
module tfew_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tfew_pkg::ctl_t c_in,
  input  logic [tfew_pkg::QW-1:0] num_r,
  input  logic [tfew_pkg::QW-1:0] num_i,
  input  logic [tfew_pkg::DW-1:0] den,
  output tfew_pkg::ctl_t c_out,
  output logic [tfew_pkg::QW-1:0] q_r,
  output logic [tfew_pkg::QW-1:0] q_i
);

  localparam int QW = tfew_pkg::QW;
  localparam int DW = tfew_pkg::DW;

  // one quotient bit per stage; numerator bits shift out as quotient bits shift in
  tfew_pkg::ctl_t c [0:QW-1];
  tfew_pkg::ctl_t c_nxt [0:QW-1];
  logic [QW-1:0] sr [0:QW-1];
  logic [QW-1:0] si [0:QW-1];
  logic [DW-1:0] rr [0:QW-1];
  logic [DW-1:0] ri [0:QW-1];
  logic [DW-1:0] d [0:QW-1];
  logic [QW-1:0] sr_nxt [0:QW-1];
  logic [QW-1:0] si_nxt [0:QW-1];
  logic [DW-1:0] rr_nxt [0:QW-1];
  logic [DW-1:0] ri_nxt [0:QW-1];
  logic [DW-1:0] d_nxt [0:QW-1];

  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QW-1:0] sh,
                                                input logic [DW-1:0] dv);
    logic [DW:0] t;
    logic [DW+1:0] diff;
    t = {rem, sh[QW-1]};
    diff = {1'b0, t} - {2'b0, dv};
    if (!diff[DW+1]) begin
      div_step = {diff[DW-1:0], sh[QW-2:0], 1'b1};
    end else begin
      div_step = {t[DW-1:0], sh[QW-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        c_nxt[k] = c_in;
        d_nxt[k] = den;
        {rr_nxt[k], sr_nxt[k]} = div_step('0, num_r, den);
        {ri_nxt[k], si_nxt[k]} = div_step('0, num_i, den);
      end else begin
        c_nxt[k] = c[k-1];
        d_nxt[k] = d[k-1];
        {rr_nxt[k], sr_nxt[k]} = div_step(rr[k-1], sr[k-1], d[k-1]);
        {ri_nxt[k], si_nxt[k]} = div_step(ri[k-1], si[k-1], d[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        c[k].vld <= 1'b0;
      end else if (en) begin
        c[k].vld <= c_nxt[k].vld;
      end
      if (en) begin
        c[k].last <= c_nxt[k].last;
        c[k].zero <= c_nxt[k].zero;
        c[k].rneg <= c_nxt[k].rneg;
        c[k].ineg <= c_nxt[k].ineg;
        sr[k] <= sr_nxt[k];
        si[k] <= si_nxt[k];
        rr[k] <= rr_nxt[k];
        ri[k] <= ri_nxt[k];
        d[k] <= d_nxt[k];
      end
    end
  end

  assign c_out = c[QW-1];
  assign q_r = sr[QW-1];
  assign q_i = si[QW-1];

endmodule

@@ hdl/tfew_clamp.sv @@
`timescale 1ns / 1ps
module tfew_clamp (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic clamp_en,
  input  tfew_pkg::ctl_t c_in,
  input  logic [tfew_pkg::QW-1:0] q_r,
  input  logic [tfew_pkg::QW-1:0] q_i,
  output tfew_pkg::res_t res
);

  localparam int QW = tfew_pkg::QW;
  localparam int W = tfew_pkg::W;
  localparam int F = tfew_pkg::FRAC_BITS;
  localparam int AW = W - 1;
  localparam int NS = 4;
  localparam int RT = W;
  localparam int QS = F + 1;
  localparam int SHF [0:2*NS-1] = '{64, 32, 16, 8, 4, 2, 1, 1};
  localparam int LOB [0:2*NS-1] = '{95, 63, 47, 39, 35, 33, 32, 31};

  typedef struct packed {
    logic vld;
    logic last;
    logic zero;
    logic rneg;
    logic ineg;
    logic kpos;
    logic big;
    logic sat;
    logic [W-1:0] tr_s;
    logic [W-1:0] ti_s;
  } side_t;

  function automatic logic [W-1:0] enc(input logic neg, input logic [W-1:0] m);
    enc = neg ? (~m + W'(1)) : m;
  endfunction

  // saturating result for the unclamped mode
  logic nzr, nzi, rneg0, ineg0, ovr, ovi;
  logic [W-1:0] limr, limi;

  assign nzr = |q_r;
  assign nzi = |q_i;
  assign rneg0 = c_in.rneg & nzr;
  assign ineg0 = c_in.ineg & nzi;
  assign limr = rneg0 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign limi = ineg0 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign ovr = (|q_r[QW-1:W]) || (q_r[W-1:0] > limr);
  assign ovi = (|q_i[QW-1:W]) || (q_i[W-1:0] > limi);

  // normalizing shift, two steps per stage
  side_t ns [0:NS-1];
  side_t ns_nxt [0:NS-1];
  logic [QW-1:0] na [0:NS-1];
  logic [QW-1:0] nb [0:NS-1];
  logic [QW-1:0] na_nxt [0:NS-1];
  logic [QW-1:0] nb_nxt [0:NS-1];

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        ns_nxt[j].vld = c_in.vld;
        ns_nxt[j].last = c_in.last;
        ns_nxt[j].zero = c_in.zero;
        ns_nxt[j].rneg = rneg0;
        ns_nxt[j].ineg = ineg0;
        ns_nxt[j].kpos = 1'b0;
        ns_nxt[j].big = 1'b0;
        ns_nxt[j].sat = ovr | ovi;
        ns_nxt[j].tr_s = enc(rneg0, ovr ? limr : q_r[W-1:0]);
        ns_nxt[j].ti_s = enc(ineg0, ovi ? limi : q_i[W-1:0]);
        na_nxt[j] = q_r;
        nb_nxt[j] = q_i;
      end else begin
        ns_nxt[j] = ns[j-1];
        na_nxt[j] = na[j-1];
        nb_nxt[j] = nb[j-1];
      end
      for (int s = 0; s < 2; s++) begin
        if (((na_nxt[j] | nb_nxt[j]) >> LOB[2*j+s]) != '0) begin
          na_nxt[j] = na_nxt[j] >> SHF[2*j+s];
          nb_nxt[j] = nb_nxt[j] >> SHF[2*j+s];
          ns_nxt[j].kpos = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (rst) begin
        ns[j].vld <= 1'b0;
      end else if (en) begin
        ns[j].vld <= ns_nxt[j].vld;
      end
      if (en) begin
        ns[j][$bits(side_t)-2:0] <= ns_nxt[j][$bits(side_t)-2:0];
        na[j] <= na_nxt[j];
        nb[j] <= nb_nxt[j];
      end
    end
  end

  // squares, then sum and compare with one
  side_t s5, s6, s5_big;
  logic [AW-1:0] a5, b5, a6, b6;
  logic [2*AW-1:0] sqa, sqb;
  logic [2*AW:0] x6;
  logic [2*AW:0] sum5;

  assign sum5 = (2*AW+1)'(sqa) + (2*AW+1)'(sqb);

  always_comb begin
    s5_big = s5;
    s5_big.big = s5.kpos || (sum5 > ((2*AW+1)'(1) << (2*F)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.vld <= 1'b0;
      s6.vld <= 1'b0;
    end else if (en) begin
      s5.vld <= ns[NS-1].vld;
      s6.vld <= s5.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5[$bits(side_t)-2:0] <= ns[NS-1][$bits(side_t)-2:0];
      a5 <= na[NS-1][AW-1:0];
      b5 <= nb[NS-1][AW-1:0];
      sqa <= na[NS-1][AW-1:0] * na[NS-1][AW-1:0];
      sqb <= nb[NS-1][AW-1:0] * nb[NS-1][AW-1:0];
      s6[$bits(side_t)-2:0] <= s5_big[$bits(side_t)-2:0];
      a6 <= a5;
      b6 <= b5;
      x6 <= sum5;
    end
  end

  // square root, one root bit per stage
  side_t qs [0:RT-1];
  side_t qs_nxt [0:RT-1];
  logic [AW-1:0] qa [0:RT-1];
  logic [AW-1:0] qb [0:RT-1];
  logic [AW-1:0] qa_nxt [0:RT-1];
  logic [AW-1:0] qb_nxt [0:RT-1];
  logic [W+3:0] rem [0:RT-1];
  logic [W+3:0] rem_nxt [0:RT-1];
  logic [W-1:0] root [0:RT-1];
  logic [W-1:0] root_nxt [0:RT-1];
  logic [2*W-1:0] xs [0:RT-1];
  logic [2*W-1:0] xs_nxt [0:RT-1];

  always_comb begin
    for (int k = 0; k < RT; k++) begin
      logic [W+3:0] r2, t;
      logic [W+3:0] r0;
      logic [W-1:0] rt0;
      logic [2*W-1:0] x0;
      if (k == 0) begin
        qs_nxt[k] = s6;
        qa_nxt[k] = a6;
        qb_nxt[k] = b6;
        r0 = '0;
        rt0 = '0;
        x0 = (2*W)'(x6);
      end else begin
        qs_nxt[k] = qs[k-1];
        qa_nxt[k] = qa[k-1];
        qb_nxt[k] = qb[k-1];
        r0 = rem[k-1];
        rt0 = root[k-1];
        x0 = xs[k-1];
      end
      r2 = {r0[W+1:0], x0[2*W-1:2*W-2]};
      t = {2'b00, rt0, 2'b01};
      if (r2 >= t) begin
        rem_nxt[k] = r2 - t;
        root_nxt[k] = {rt0[W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2;
        root_nxt[k] = {rt0[W-2:0], 1'b0};
      end
      xs_nxt[k] = {x0[2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RT; k++) begin
      if (rst) begin
        qs[k].vld <= 1'b0;
      end else if (en) begin
        qs[k].vld <= qs_nxt[k].vld;
      end
      if (en) begin
        qs[k][$bits(side_t)-2:0] <= qs_nxt[k][$bits(side_t)-2:0];
        qa[k] <= qa_nxt[k];
        qb[k] <= qb_nxt[k];
        rem[k] <= rem_nxt[k];
        root[k] <= root_nxt[k];
        xs[k] <= xs_nxt[k];
      end
    end
  end

  // a*2^F / m and b*2^F / m; quotient at most 2^F, one bit per stage
  side_t ds [0:QS-1];
  side_t ds_nxt [0:QS-1];
  logic [AW-1:0] da [0:QS-1];
  logic [AW-1:0] db [0:QS-1];
  logic [AW-1:0] da_nxt [0:QS-1];
  logic [AW-1:0] db_nxt [0:QS-1];
  logic [W-1:0] dm [0:QS-1];
  logic [W-1:0] dm_nxt [0:QS-1];
  logic [W-1:0] ra [0:QS-1];
  logic [W-1:0] rb [0:QS-1];
  logic [W-1:0] ra_nxt [0:QS-1];
  logic [W-1:0] rb_nxt [0:QS-1];
  logic [QS-1:0] ha [0:QS-1];
  logic [QS-1:0] hb [0:QS-1];
  logic [QS-1:0] ha_nxt [0:QS-1];
  logic [QS-1:0] hb_nxt [0:QS-1];

  function automatic logic [W+QS-1:0] qstep(input logic [W-1:0] r,
                                            input logic [QS-1:0] h,
                                            input logic [W-1:0] m);
    logic [W:0] t;
    t = {r, h[QS-1]};
    if (t >= {1'b0, m}) begin
      qstep = {W'(t - {1'b0, m}), h[QS-2:0], 1'b1};
    end else begin
      qstep = {t[W-1:0], h[QS-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    for (int k = 0; k < QS; k++) begin
      if (k == 0) begin
        ds_nxt[k] = qs[RT-1];
        da_nxt[k] = qa[RT-1];
        db_nxt[k] = qb[RT-1];
        dm_nxt[k] = root[RT-1];
        {ra_nxt[k], ha_nxt[k]} = qstep(W'(qa[RT-1][AW-1:1]),
                                       {qa[RT-1][0], {F{1'b0}}}, root[RT-1]);
        {rb_nxt[k], hb_nxt[k]} = qstep(W'(qb[RT-1][AW-1:1]),
                                       {qb[RT-1][0], {F{1'b0}}}, root[RT-1]);
      end else begin
        ds_nxt[k] = ds[k-1];
        da_nxt[k] = da[k-1];
        db_nxt[k] = db[k-1];
        dm_nxt[k] = dm[k-1];
        {ra_nxt[k], ha_nxt[k]} = qstep(ra[k-1], ha[k-1], dm[k-1]);
        {rb_nxt[k], hb_nxt[k]} = qstep(rb[k-1], hb[k-1], dm[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QS; k++) begin
      if (rst) begin
        ds[k].vld <= 1'b0;
      end else if (en) begin
        ds[k].vld <= ds_nxt[k].vld;
      end
      if (en) begin
        ds[k][$bits(side_t)-2:0] <= ds_nxt[k][$bits(side_t)-2:0];
        da[k] <= da_nxt[k];
        db[k] <= db_nxt[k];
        dm[k] <= dm_nxt[k];
        ra[k] <= ra_nxt[k];
        rb[k] <= rb_nxt[k];
        ha[k] <= ha_nxt[k];
        hb[k] <= hb_nxt[k];
      end
    end
  end

  // result select
  side_t fs;
  tfew_pkg::res_t res_next;

  assign fs = ds[QS-1];

  always_comb begin
    res_next.vld = fs.vld;
    res_next.last = fs.last;
    res_next.zero = 1'b0;
    res_next.clamped = 1'b0;
    res_next.sat = 1'b0;
    res_next.tr = '0;
    res_next.ti = '0;
    if (fs.zero) begin
      res_next.zero = 1'b1;
    end else if (clamp_en) begin
      if (fs.big) begin
        res_next.clamped = 1'b1;
        res_next.tr = enc(fs.rneg, W'(ha[QS-1]));
        res_next.ti = enc(fs.ineg, W'(hb[QS-1]));
      end else begin
        res_next.tr = enc(fs.rneg, W'(da[QS-1]));
        res_next.ti = enc(fs.ineg, W'(db[QS-1]));
      end
    end else begin
      res_next.sat = fs.sat;
      res_next.tr = fs.tr_s;
      res_next.ti = fs.ti_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else if (en) begin
      res.vld <= res_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res[$bits(tfew_pkg::res_t)-2:0] <= res_next[$bits(tfew_pkg::res_t)-2:0];
    end
  end

endmodule

@@ hdl/transmission_from_exit_wave.sv @@
`timescale 1ns / 1ps
// Per-pixel transmission T = conj(L)(E+L)/|L|^2 with L = illum_norm * I, Q16.16 in and out.
// One pixel is accepted per clock unless the output buffer is full and out_ready is low. The
// path holds the 111-stage bit-per-stage quotient pipeline, the 32-stage square root and
// the 17-stage clamp divider. A two-entry buffer on the output lets the pipeline keep
// moving and taking pixels while one result waits. Configuration is taken at any time
// but must only change while no pixel is in flight.
module transmission_from_exit_wave (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] wave_real,
  input  logic signed [31:0] wave_imag,
  input  logic signed [31:0] light_real,
  input  logic signed [31:0] light_imag,
  input  logic last_pixel,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] trans_real,
  output logic signed [31:0] trans_imag,
  output logic zero_light,
  output logic was_clamped,
  output logic saturated,
  output logic last_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] illum_norm;
  logic unity_clamp_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      illum_norm <= 32'sd65536;
      unity_clamp_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfew_pkg::CFG_ILLUM_NORM: illum_norm <= cfg_data;
        tfew_pkg::CFG_UNITY_CLAMP: unity_clamp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  tfew_pkg::ctl_t f_ctl, d_ctl;
  logic [tfew_pkg::QW-1:0] f_nr, f_ni, d_qr, d_qi;
  logic [tfew_pkg::DW-1:0] f_den;
  tfew_pkg::res_t c_res;

  tfew_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid),
    .wr(wave_real), .wi(wave_imag), .lr(light_real), .li(light_imag),
    .last_in(last_pixel), .norm(illum_norm),
    .ctl(f_ctl), .num_r(f_nr), .num_i(f_ni), .den(f_den)
  );

  tfew_div u_div (
    .clk(clk), .rst(rst), .en(en), .c_in(f_ctl),
    .num_r(f_nr), .num_i(f_ni), .den(f_den),
    .c_out(d_ctl), .q_r(d_qr), .q_i(d_qi)
  );

  tfew_clamp u_clamp (
    .clk(clk), .rst(rst), .en(en), .clamp_en(unity_clamp_enable),
    .c_in(d_ctl), .q_r(d_qr), .q_i(d_qi), .res(c_res)
  );

  // output buffer
  tfew_pkg::res_t buf_q [0:1];
  logic wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic push, pop;

  assign en = (cnt != 2'd2) || out_ready;
  assign in_ready = en;
  assign push = en && c_res.vld;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= c_res;
  end

  assign out_valid = (cnt != 2'd0);
  assign trans_real = buf_q[rd_ptr].tr;
  assign trans_imag = buf_q[rd_ptr].ti;
  assign zero_light = buf_q[rd_ptr].zero;
  assign was_clamped = buf_q[rd_ptr].clamped;
  assign saturated = buf_q[rd_ptr].sat;
  assign last_out = buf_q[rd_ptr].last;

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("output buffer overflow");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_light |-> trans_real == 0 && trans_imag == 0 && !was_clamped && !saturated)
    else $error("zero-light transaction carries data");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_clamped && saturated))
    else $error("clamped and saturated together");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule
